// File: src/assert_macros.svh
// Assertion macros shared by the voxel boundary face extractor.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a condition holds at every clock edge
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// check that the antecedent implies the consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that the antecedent implies the consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/vbf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the per-face corner table of the voxel boundary face extractor.
// No dependencies.
package vbf_pkg;

  localparam int COORD_W    = 4;
  localparam int DIM_W      = 5;
  localparam int CORNER_W   = 13;
  localparam int FACE_W     = 3;
  localparam int NUM_FACES  = 6;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;

  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [FACE_W-1:0] FACE_PZ = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PX = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd5;

  localparam logic [CNT_W-1:0] RD_CENTER = 3'd0;
  localparam logic [CNT_W-1:0] RD_PZ     = 3'd1;
  localparam logic [CNT_W-1:0] RD_NZ     = 3'd2;
  localparam logic [CNT_W-1:0] RD_PY     = 3'd3;
  localparam logic [CNT_W-1:0] RD_NY     = 3'd4;
  localparam logic [CNT_W-1:0] RD_PX     = 3'd5;
  localparam logic [CNT_W-1:0] RD_NX     = 3'd6;

  // corner code: bit0 +1 in x, bit1 +1 in y, bit2 +1 in z
  localparam logic [2:0] FACE_CORNERS [NUM_FACES][NUM_FACES] = '{
    '{3'd5, 3'd4, 3'd6, 3'd5, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd2},
    '{3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6},
    '{3'd0, 3'd5, 3'd1, 3'd0, 3'd4, 3'd5},
    '{3'd1, 3'd5, 3'd7, 3'd1, 3'd7, 3'd3},
    '{3'd4, 3'd0, 3'd2, 3'd4, 3'd2, 3'd6}
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              ready;
    logic              clear;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_sel;
    logic              load_out;
    logic [FACE_W-1:0] face;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic                 in_valid;
    logic                 in_extract;
    logic                 in_grid;
    logic                 clear_last;
    logic                 center_full;
    logic [NUM_FACES-1:0] exposed;
    logic                 out_free;
  } status_t;

  function automatic logic [2:0] corner_code(input logic [FACE_W-1:0] f,
                                             input logic [2:0] k);
    logic [2:0] code;
    code = '0;
    if (f < FACE_W'(NUM_FACES) && k < 3'(NUM_FACES)) begin
      code = FACE_CORNERS[f][k];
    end
    return code;
  endfunction

endpackage

// File: src/voxel_boundary_face_extract.sv
`timescale 1ns / 1ps
// Writes and out-of-grid requests are taken in the idle state. An in-grid extract makes 7
// single-port occupancy reads (center, then six neighbors), passes a settle state, then
// takes one step per face of a filled cell; an empty cell emits no face.
// Output stalls hold the face step. Reset (synchronous, rst high) starts a clearing pass over
// all MAX_CELLS**3 cells, one cell a cycle, with s_tready low.
module voxel_boundary_face_extract #(
  parameter int MAX_CELLS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [vbf_pkg::IN_DATA_W-1:0]  s_tdata,   // cell_x, cell_y, cell_z, filled, 3'b0
  input  logic                           s_tuser,   // cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [vbf_pkg::OUT_DATA_W-1:0] m_tdata,   // corner_a .. corner_f, 2'b0
  output logic [vbf_pkg::FACE_W-1:0]     m_tuser,   // face
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [vbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbf_pkg::DIM_W-1:0]      cfg_data
);
  import vbf_pkg::*;

  cmd_t    cmd;
  status_t st;

  vbf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  vbf_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// File: src/vbf_ctrl.sv
`timescale 1ns / 1ps
// Controller of the voxel boundary face extractor: clear pass, neighbor reads, face emission.
// Depends on vbf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vbf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  vbf_pkg::status_t st,
  output vbf_pkg::cmd_t    cmd
);
  import vbf_pkg::*;

  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 accept;
  logic [NUM_FACES-1:0] above_mask;
  logic                 is_last;

  assign accept     = (state == ST_IDLE) && st.in_valid;
  assign above_mask = NUM_FACES'(6'h3e << cnt);
  assign is_last    = (st.exposed & above_mask) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_CLEAR: begin
        if (st.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && st.in_extract && st.in_grid) begin
          state_next = ST_READ;
          cnt_next   = '0;
        end
      end
      ST_READ: begin
        if (cnt == RD_NX) begin
          state_next = ST_SETTLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SETTLE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!st.center_full) begin
          state_next = ST_IDLE;
        end else if (!st.exposed[cnt] || st.out_free) begin
          if (cnt == FACE_NX) state_next = ST_IDLE;
          else cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = cnt;
    cmd.face   = cnt;
    cmd.last   = is_last;
    unique case (state)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE:   cmd.ready = 1'b1;
      ST_READ:   cmd.rd_en = 1'b1;
      ST_SETTLE: cmd.rd_en = 1'b0;
      ST_EMIT:   cmd.load_out = st.center_full && st.exposed[cnt] && st.out_free;
      default:   cmd.clear = 1'b0;
    endcase
  end

  `ASSERT_NEXT(a_no_load_after_last, cmd.load_out && cmd.last, !cmd.load_out)
  `ASSERT_IMPLIES(a_empty_no_load, !st.center_full, !cmd.load_out)
  `ASSERT_IMPLIES(a_read_entry, (state == ST_READ) && (cnt == RD_CENTER), $past(st.in_valid && st.in_extract && st.in_grid))

endmodule

// File: src/vbf_datapath.sv
`timescale 1ns / 1ps
// Datapath of the voxel boundary face extractor: dimension registers, occupancy memory,
// neighbor capture, corner index arithmetic and the output register. Depends on vbf_pkg.
`include "assert_macros.svh"
module vbf_datapath #(
  parameter int MAX_CELLS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [vbf_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [vbf_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [vbf_pkg::FACE_W-1:0]       m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [vbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vbf_pkg::DIM_W-1:0]        cfg_data,
  input  vbf_pkg::cmd_t                    cmd,
  output vbf_pkg::status_t                 st
);
  import vbf_pkg::*;

  localparam int PLANE  = MAX_CELLS * MAX_CELLS;
  localparam int DEPTH  = PLANE * MAX_CELLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [6:0] MAX_DIM = 7'(MAX_CELLS);

  logic [DIM_W-1:0]    cells_x, cells_y, cells_z;
  logic [DIM_W-1:0]    nx, ny, nz;
  logic [COORD_W-1:0]  in_x, in_y, in_z;
  logic                in_fill;
  logic                accept;
  logic [COORD_W-1:0]  cx, cy, cz;
  logic [ADDR_W-1:0]   in_addr, ctr_addr, rd_addr, mem_addr, clr_addr;
  logic                mem_we, mem_wd;
  logic                occ [DEPTH];
  logic                occ_q;
  logic                rd_pend;
  logic [CNT_W-1:0]    rd_pend_sel;
  logic [6:0]          nb;
  logic                top_x, top_y, top_z, bot_x, bot_y, bot_z;
  logic [DIM_W:0]      nx1, ny1;
  logic [CORNER_W-1:0] sy_q, sz_q, zs_q, yx_q, base_q;
  logic [2:0]          code [NUM_FACES];
  logic [CORNER_W-1:0] corner [NUM_FACES];
  logic                out_valid;
  logic [FACE_W-1:0]   out_face;
  logic [CORNER_W-1:0] out_corner [NUM_FACES];
  logic                out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= DIM_RESET;
      cells_y <= DIM_RESET;
      cells_z <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELLS_X: cells_x <= cfg_data;
        CFG_CELLS_Y: cells_y <= cfg_data;
        CFG_CELLS_Z: cells_z <= cfg_data;
        default:     cells_x <= cells_x;
      endcase
    end
  end

  assign nx = ({2'b00, cells_x} > MAX_DIM) ? DIM_W'(MAX_CELLS) : cells_x;
  assign ny = ({2'b00, cells_y} > MAX_DIM) ? DIM_W'(MAX_CELLS) : cells_y;
  assign nz = ({2'b00, cells_z} > MAX_DIM) ? DIM_W'(MAX_CELLS) : cells_z;

  assign in_x    = s_tdata[3:0];
  assign in_y    = s_tdata[7:4];
  assign in_z    = s_tdata[11:8];
  assign in_fill = s_tdata[12];

  assign s_tready = cmd.ready;
  assign accept   = s_tvalid && cmd.ready;

  assign st.in_valid   = s_tvalid;
  assign st.in_extract = (s_tuser == CMD_EXTRACT);
  assign st.in_grid    = ({1'b0, in_x} < nx) && ({1'b0, in_y} < ny) && ({1'b0, in_z} < nz);

  always_ff @(posedge clk) begin
    if (accept) begin
      cx <= in_x;
      cy <= in_y;
      cz <= in_z;
    end
  end

  assign in_addr  = ADDR_W'(int'(in_z) * PLANE + int'(in_y) * MAX_CELLS + int'(in_x));
  assign ctr_addr = ADDR_W'(int'(cz) * PLANE + int'(cy) * MAX_CELLS + int'(cx));

  assign top_x = ({1'b0, cx} + 5'd1) == nx;
  assign top_y = ({1'b0, cy} + 5'd1) == ny;
  assign top_z = ({1'b0, cz} + 5'd1) == nz;
  assign bot_x = (cx == '0);
  assign bot_y = (cy == '0);
  assign bot_z = (cz == '0);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PZ:   rd_addr = top_z ? ctr_addr : ctr_addr + ADDR_W'(PLANE);
      RD_NZ:   rd_addr = bot_z ? ctr_addr : ctr_addr - ADDR_W'(PLANE);
      RD_PY:   rd_addr = top_y ? ctr_addr : ctr_addr + ADDR_W'(MAX_CELLS);
      RD_NY:   rd_addr = bot_y ? ctr_addr : ctr_addr - ADDR_W'(MAX_CELLS);
      RD_PX:   rd_addr = top_x ? ctr_addr : ctr_addr + ADDR_W'(1);
      RD_NX:   rd_addr = bot_x ? ctr_addr : ctr_addr - ADDR_W'(1);
      default: rd_addr = ctr_addr;
    endcase
  end

  assign mem_we   = cmd.clear || (accept && (s_tuser == CMD_WRITE) && st.in_grid);
  assign mem_wd   = cmd.clear ? 1'b0 : in_fill;
  assign mem_addr = cmd.clear ? clr_addr : (cmd.rd_en ? rd_addr : in_addr);

  always_ff @(posedge clk) begin
    if (mem_we) occ[mem_addr] <= mem_wd;
    occ_q <= occ[mem_addr];
  end

  assign st.clear_last = (clr_addr == ADDR_W'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear && !st.clear_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_pend_sel <= cmd.rd_sel;
    if (rd_pend) nb[rd_pend_sel] <= occ_q;
  end

  assign st.center_full = nb[RD_CENTER];
  assign st.exposed[FACE_PZ] = top_z || !nb[RD_PZ];
  assign st.exposed[FACE_NZ] = bot_z || !nb[RD_NZ];
  assign st.exposed[FACE_PY] = top_y || !nb[RD_PY];
  assign st.exposed[FACE_NY] = bot_y || !nb[RD_NY];
  assign st.exposed[FACE_PX] = top_x || !nb[RD_PX];
  assign st.exposed[FACE_NX] = bot_x || !nb[RD_NX];

  assign nx1 = {1'b0, nx} + 6'd1;
  assign ny1 = {1'b0, ny} + 6'd1;

  always_ff @(posedge clk) begin
    sy_q   <= CORNER_W'(nx1);
    sz_q   <= CORNER_W'(12'(nx1) * 12'(ny1));
    zs_q   <= CORNER_W'(cz) * sz_q;
    yx_q   <= CORNER_W'(cy) * sy_q + CORNER_W'(cx);
    base_q <= zs_q + yx_q;
  end

  always_comb begin
    for (int k = 0; k < NUM_FACES; k++) begin
      code[k]   = corner_code(cmd.face, 3'(k));
      corner[k] = base_q + CORNER_W'(code[k][0])
                + (code[k][1] ? sy_q : '0)
                + (code[k][2] ? sz_q : '0);
    end
  end

  assign st.out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_face   <= cmd.face;
      out_corner <= corner;
      out_last   <= cmd.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_face;
  assign m_tlast  = out_last;
  assign m_tdata  = {2'b00, out_corner[5], out_corner[4], out_corner[3],
                     out_corner[2], out_corner[1], out_corner[0]};

  `ASSERT_IMPLIES(a_load_slot_free, cmd.load_out, st.out_free)
  `ASSERT_IMPLIES(a_accept_quiet, accept, !rd_pend && !cmd.clear)
  `ASSERT_IMPLIES(a_read_exclusive, cmd.rd_en, !accept && !cmd.clear)

endmodule

// File: tb/sv/vbf_face_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the voxel boundary face extractor: watches the request, result and
// register write channels, predicts the faces per extract and compares. Needs vbf_pkg.
module vbf_face_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [vbf_pkg::IN_DATA_W-1:0]  s_tdata,   // cell_x, cell_y, cell_z, filled, 3'b0
  input  logic                           s_tuser,   // cmd
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [vbf_pkg::OUT_DATA_W-1:0] m_tdata,   // corner_a .. corner_f, 2'b0
  input  logic [vbf_pkg::FACE_W-1:0]     m_tuser,   // face
  input  logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [vbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbf_pkg::DIM_W-1:0]      cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             results_seen
);
  import vbf_pkg::*;

  localparam int GRID_MAX = 16;

  // corner code: bit0 +x, bit1 +y, bit2 +z
  localparam logic [2:0] QUAD_CORNERS [6][6] = '{
    '{3'd5, 3'd4, 3'd6, 3'd5, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd2},
    '{3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6},
    '{3'd0, 3'd5, 3'd1, 3'd0, 3'd4, 3'd5},
    '{3'd1, 3'd5, 3'd7, 3'd1, 3'd7, 3'd3},
    '{3'd4, 3'd0, 3'd2, 3'd4, 3'd2, 3'd6}
  };

  typedef struct packed {
    logic [FACE_W-1:0]         face;
    logic [5:0][CORNER_W-1:0]  corner;
    logic                      last;
  } face_rec_t;

  face_rec_t        face_q [$];
  logic             occupied [GRID_MAX*GRID_MAX*GRID_MAX];
  logic [DIM_W-1:0] dim_x;
  logic [DIM_W-1:0] dim_y;
  logic [DIM_W-1:0] dim_z;
  int               fails = 0;
  int               seen = 0;

  function automatic int cell_at(input int x, input int y, input int z);
    return (z * GRID_MAX + y) * GRID_MAX + x;
  endfunction

  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    return (v > GRID_MAX) ? GRID_MAX : int'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at result %0d, %s: got %0d, want %0d", seen, what, got, want);
    fails++;
  endtask

  function automatic void emit_exposed_faces(input logic cmd, input int x, input int y,
                                             input int z, input logic fill);
    int         nx;
    int         ny;
    int         nz;
    logic [5:0] open;
    logic [2:0] code;
    face_rec_t  rec;
    nx = clamp_dim(dim_x);
    ny = clamp_dim(dim_y);
    nz = clamp_dim(dim_z);
    if (x >= nx || y >= ny || z >= nz) return;
    if (cmd == CMD_WRITE) begin
      occupied[cell_at(x, y, z)] = fill;
      return;
    end
    if (!occupied[cell_at(x, y, z)]) return;
    open[0] = (z + 1 == nz) || !occupied[cell_at(x, y, z + 1)];
    open[1] = (z == 0) || !occupied[cell_at(x, y, z - 1)];
    open[2] = (y + 1 == ny) || !occupied[cell_at(x, y + 1, z)];
    open[3] = (y == 0) || !occupied[cell_at(x, y - 1, z)];
    open[4] = (x + 1 == nx) || !occupied[cell_at(x + 1, y, z)];
    open[5] = (x == 0) || !occupied[cell_at(x - 1, y, z)];
    for (int f = 0; f < 6; f++) begin
      if (open[f]) begin
        rec.face = FACE_W'(f);
        for (int k = 0; k < 6; k++) begin
          code = QUAD_CORNERS[f][k];
          rec.corner[k] = CORNER_W'((z + code[2]) * (ny + 1) * (nx + 1) +
                                    (y + code[1]) * (nx + 1) + x + code[0]);
        end
        rec.last = ((open >> (f + 1)) == 6'd0);
        face_q = {face_q, rec};
      end
    end
  endfunction

  always @(posedge clk) begin
    face_rec_t want;
    if (rst) begin
      for (int i = 0; i < GRID_MAX * GRID_MAX * GRID_MAX; i++) occupied[i] = 1'b0;
      dim_x = DIM_RESET;
      dim_y = DIM_RESET;
      dim_z = DIM_RESET;
      face_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (face_q.size() == 0) begin
          report_mismatch("face with nothing expected", int'(m_tuser), -1);
        end else begin
          want = face_q.pop_front();
          if (m_tuser !== want.face) report_mismatch("face", int'(m_tuser), int'(want.face));
          for (int k = 0; k < 6; k++) begin
            if (m_tdata[k*CORNER_W +: CORNER_W] !== want.corner[k])
              report_mismatch($sformatf("corner %0d", k),
                              int'(m_tdata[k*CORNER_W +: CORNER_W]), int'(want.corner[k]));
          end
          if (m_tlast !== want.last) report_mismatch("last", int'(m_tlast), int'(want.last));
        end
        seen++;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CELLS_X: dim_x = cfg_data;
          CFG_CELLS_Y: dim_y = cfg_data;
          CFG_CELLS_Z: dim_z = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        emit_exposed_faces(s_tuser, int'(s_tdata[3:0]), int'(s_tdata[7:4]),
                           int'(s_tdata[11:8]), s_tdata[12]);
    end
    pending <= face_q.size();
    mismatches <= fails;
    results_seen <= seen;
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the voxel boundary face extractor bench: clock, reset, requests, grid settings
// and the verdict. Needs vbf_pkg, vbf_face_checker and voxel_boundary_face_extract.
module testbench;
  import vbf_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tuser = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]      cfg_data = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [FACE_W-1:0]     m_tuser;
  logic                  m_tlast;

  int mismatches;
  int pending;
  int results_seen;
  bit idle_on = 1'b1;
  int rx_hold = 0;
  int rx_draw;
  int requests_sent = 0;
  int extracts_sent = 0;
  int grid_settings = 0;
  int cur_x = 16;
  int cur_y = 16;
  int cur_z = 16;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  voxel_boundary_face_extract u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  vbf_face_checker u_check (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .pending, .results_seen
  );

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= (rx_hold == 1);
    end else if (m_tvalid && m_tready && idle_on) begin
      rx_draw = $urandom_range(0, 3);
      rx_hold <= rx_draw;
      m_tready <= (rx_draw == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic cmd, input int x, input int y, input int z,
                              input logic fill);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {3'b000, fill, 4'(z), 4'(y), 4'(x)};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (cmd == CMD_EXTRACT) extracts_sent++;
  endtask

  // drop valid, drain every expected face, then cover the tail of an empty extract
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_dims(input int x, input int y, input int z);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CELLS_X;
    cfg_data <= DIM_W'(x);
    @(posedge clk);
    cfg_index <= CFG_CELLS_Y;
    cfg_data <= DIM_W'(y);
    @(posedge clk);
    cfg_index <= CFG_CELLS_Z;
    cfg_data <= DIM_W'(z);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_x = (x > 16) ? 16 : x;
    cur_y = (y > 16) ? 16 : y;
    cur_z = (z > 16) ? 16 : z;
    grid_settings++;
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 7))
      0: return 1;
      1: return 16;
      2: return $urandom_range(17, 31);
      default: return $urandom_range(2, 5);
    endcase
  endfunction

  // mostly in-grid cells so writes and extracts hit each other; random dims are never 0
  task automatic random_request();
    logic cmd;
    logic fill;
    int   x;
    int   y;
    int   z;
    cmd = 1'($urandom_range(0, 1));
    fill = ($urandom_range(0, 9) < 7);
    if ($urandom_range(0, 9) < 8) begin
      x = $urandom_range(0, cur_x - 1);
      y = $urandom_range(0, cur_y - 1);
      z = $urandom_range(0, cur_z - 1);
    end else begin
      x = $urandom_range(0, 15);
      y = $urandom_range(0, 15);
      z = $urandom_range(0, 15);
    end
    send_request(cmd, x, y, z, fill);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    set_dims(16, 16, 16);

    send_request(CMD_WRITE, 0, 0, 0, 1'b1);
    send_request(CMD_EXTRACT, 0, 0, 0, 1'b0);
    send_request(CMD_WRITE, 15, 15, 15, 1'b1);
    send_request(CMD_EXTRACT, 15, 15, 15, 1'b0);
    send_request(CMD_WRITE, 5, 5, 5, 1'b1);
    send_request(CMD_WRITE, 6, 5, 5, 1'b1);
    send_request(CMD_WRITE, 5, 6, 5, 1'b1);
    send_request(CMD_WRITE, 5, 5, 6, 1'b1);
    send_request(CMD_WRITE, 5, 5, 4, 1'b1);
    send_request(CMD_WRITE, 5, 4, 5, 1'b1);
    send_request(CMD_WRITE, 4, 5, 5, 1'b1);
    send_request(CMD_EXTRACT, 5, 5, 5, 1'b1);
    send_request(CMD_WRITE, 6, 5, 5, 1'b0);
    send_request(CMD_EXTRACT, 5, 5, 5, 1'b0);
    send_request(CMD_EXTRACT, 3, 3, 3, 1'b0);
    send_request(CMD_EXTRACT, 6, 5, 5, 1'b0);
    send_request(CMD_EXTRACT, 5, 6, 5, 1'b0);
    wait_idle();
    set_dims(1, 1, 1);
    send_request(CMD_WRITE, 1, 0, 0, 1'b1);
    send_request(CMD_EXTRACT, 0, 0, 0, 1'b0);
    send_request(CMD_EXTRACT, 1, 0, 0, 1'b0);
    wait_idle();
    set_dims(0, 0, 0);
    send_request(CMD_WRITE, 0, 0, 0, 1'b0);
    send_request(CMD_EXTRACT, 0, 0, 0, 1'b0);
    wait_idle();
    set_dims(31, 31, 31);
    send_request(CMD_EXTRACT, 15, 15, 15, 1'b0);
    send_request(CMD_EXTRACT, 0, 0, 0, 1'b0);

    for (int phase = 0; phase < 7; phase++) begin
      wait_idle();
      set_dims(pick_dim(), pick_dim(), pick_dim());
      idle_on <= (phase % 3 != 2);
      for (int i = 0; i < 50; i++) begin
        if (i == 25 && phase % 2 == 0) wait_idle();
        random_request();
      end
    end
    wait_idle();

    $display("Sent %0d requests (%0d extracts) across %0d grid settings,",
             requests_sent, extracts_sent, grid_settings);
    $display("and compared %0d face results.", results_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d faces still expected", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
